[design/nlp_pkg.sv]
// Shared types and constants for the nearest-line-to-point block.
// Used by nlp_front, nlp_fifo, nlp_back and nearest_line_to_point.
`default_nettype none

package nlp_pkg;

	localparam int COEF_W     = 16;
	localparam int IDX_W      = 10;
	localparam int PROD_W     = 32;
	localparam int NUM_W      = 34;
	localparam int ABS_W      = 32;
	localparam int SQ_W       = 64;
	localparam int DEN_W      = 32;
	localparam int MUL_W      = 32;
	localparam int WIDE_W     = 96;

	localparam int MAX_LINES  = 1024;
	localparam int POS_W      = $clog2(MAX_LINES);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_POINT_X = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POINT_Y = 1'd1;

	typedef struct packed {
		logic [SQ_W-1:0]   sq;
		logic [DEN_W-1:0]  den;
		logic [COEF_W-1:0] a;
		logic [COEF_W-1:0] b;
		logic [COEF_W-1:0] c;
		logic              degen;
		logic              hit;
		logic              last;
	} item_t;

endpackage

`default_nettype wire

[design/nlp_front.sv]
// Front part: query point registers and the distance-term pipeline.
// Forms |num|^2, den and the line flags per item; depends on nlp_pkg.
`default_nettype none

module nlp_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [nlp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [nlp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic signed [nlp_pkg::COEF_W-1:0] coef_a,
	input  wire logic signed [nlp_pkg::COEF_W-1:0] coef_b,
	input  wire logic signed [nlp_pkg::COEF_W-1:0] coef_c,
	input  wire logic                            last,
	output logic                                 q_valid,
	input  wire logic                            q_ready,
	output nlp_pkg::item_t                       q_item
);
	import nlp_pkg::*;

	logic signed [COEF_W-1:0] px_q, py_q;

	logic v_s1, v_s2, v_s3, v_s4;
	logic en;

	logic signed [PROD_W-1:0] pa_s1, pb_s1, aa_s1, bb_s1;
	logic signed [COEF_W-1:0] a_s1, b_s1, c_s1;
	logic                     degen_s1, last_s1;

	logic signed [NUM_W-1:0]  num_s2;
	logic [DEN_W-1:0]         den_s2;
	logic [COEF_W-1:0]        a_s2, b_s2, c_s2;
	logic                     degen_s2, last_s2;

	logic [ABS_W-1:0]         anum_s3;
	logic                     hit_s3;
	logic [DEN_W-1:0]         den_s3;
	logic [COEF_W-1:0]        a_s3, b_s3, c_s3;
	logic                     degen_s3, last_s3;

	item_t                    item_s4;

	assign en       = !v_s4 || q_ready;
	assign in_ready = en;
	assign q_valid  = v_s4;
	assign q_item   = item_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			px_q <= '0;
			py_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POINT_X: px_q <= $signed(cfg_data);
				REG_POINT_Y: py_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1    <= PROD_W'(coef_a) * PROD_W'(px_q);
			pb_s1    <= PROD_W'(coef_b) * PROD_W'(py_q);
			aa_s1    <= PROD_W'(coef_a) * PROD_W'(coef_a);
			bb_s1    <= PROD_W'(coef_b) * PROD_W'(coef_b);
			a_s1     <= coef_a;
			b_s1     <= coef_b;
			c_s1     <= coef_c;
			degen_s1 <= (coef_a == '0) && (coef_b == '0);
			last_s1  <= last;

			num_s2   <= NUM_W'(pa_s1) + NUM_W'(pb_s1) + NUM_W'(c_s1);
			den_s2   <= $unsigned(aa_s1) + $unsigned(bb_s1);
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			c_s2     <= c_s1;
			degen_s2 <= degen_s1;
			last_s2  <= last_s1;

			anum_s3  <= ABS_W'(num_s2 < 0 ? -num_s2 : num_s2);
			hit_s3   <= (num_s2 == '0);
			den_s3   <= den_s2;
			a_s3     <= a_s2;
			b_s3     <= b_s2;
			c_s3     <= c_s2;
			degen_s3 <= degen_s2;
			last_s3  <= last_s2;

			item_s4.sq    <= SQ_W'(anum_s3) * SQ_W'(anum_s3);
			item_s4.den   <= den_s3;
			item_s4.a     <= a_s3;
			item_s4.b     <= b_s3;
			item_s4.c     <= c_s3;
			item_s4.degen <= degen_s3;
			item_s4.hit   <= hit_s3;
			item_s4.last  <= last_s3;
		end
	end

endmodule

`default_nettype wire

[design/nlp_fifo.sv]
// Short item queue between the front pipeline and the compare engine.
// Register-based, FIFO_DEPTH entries of item_t; depends on nlp_pkg.
`default_nettype none

module nlp_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           wr_valid,
	output logic                wr_ready,
	input  wire nlp_pkg::item_t wr_item,
	output logic                rd_valid,
	input  wire logic           rd_ready,
	output nlp_pkg::item_t      rd_item
);
	import nlp_pkg::*;

	item_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic                  push, pop;

	assign wr_ready = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

`default_nettype wire

[design/nlp_back.sv]
// Back part: keeps the nearest line of the set and emits the result item.
// Exact 96-bit cross-multiplied compare on one shared 32x32 multiplier; uses nlp_pkg.
`default_nettype none

module nlp_back (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_valid,
	output logic                                   q_ready,
	input  wire nlp_pkg::item_t                    q_item,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [nlp_pkg::IDX_W-1:0]              best_index,
	output logic signed [nlp_pkg::COEF_W-1:0]      best_a,
	output logic signed [nlp_pkg::COEF_W-1:0]      best_b,
	output logic signed [nlp_pkg::COEF_W-1:0]      best_c,
	output logic                                   through_point,
	output logic                                   all_degenerate
);
	import nlp_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_M0, S_M1, S_M2, S_M3, S_M4, S_CMP, S_COMMIT
	} state_t;

	state_t             state_q;
	item_t              w_q;
	logic               take_q;

	logic [SQ_W-1:0]    bsq_q;
	logic [DEN_W-1:0]   bden_q;
	logic [COEF_W-1:0]  ba_q, bb_q, bc_q;
	logic [POS_W-1:0]   bpos_q;
	logic [POS_W-1:0]   pos_q;
	logic               bvalid_q;
	logic               hit_q;

	logic [SQ_W-1:0]    p_q;
	logic [SQ_W-1:0]    lo_q;
	logic [WIDE_W-1:0]  l_q, r_q;

	logic [MUL_W-1:0]   mul_x, mul_y;
	logic [SQ_W-1:0]    mul_p;

	logic [COEF_W-1:0]  nx_a, nx_b, nx_c;
	logic [POS_W-1:0]   nx_pos;
	logic               nx_valid;
	logic               commit_go;

	logic [IDX_W-1:0]   best_index_q;
	logic [COEF_W-1:0]  best_a_q, best_b_q, best_c_q;
	logic               through_q, all_degen_q, out_valid_q;

	always_comb begin
		mul_x = '0;
		mul_y = '0;
		unique case (state_q)
			S_M0: begin
				mul_x = w_q.sq[MUL_W-1:0];
				mul_y = bden_q;
			end
			S_M1: begin
				mul_x = w_q.sq[SQ_W-1:MUL_W];
				mul_y = bden_q;
			end
			S_M2: begin
				mul_x = bsq_q[MUL_W-1:0];
				mul_y = w_q.den;
			end
			S_M3: begin
				mul_x = bsq_q[SQ_W-1:MUL_W];
				mul_y = w_q.den;
			end
			default: ;
		endcase
	end

	assign mul_p = SQ_W'(mul_x) * SQ_W'(mul_y);

	assign nx_a     = take_q ? w_q.a : ba_q;
	assign nx_b     = take_q ? w_q.b : bb_q;
	assign nx_c     = take_q ? w_q.c : bc_q;
	assign nx_pos   = take_q ? pos_q : bpos_q;
	assign nx_valid = take_q ? !w_q.degen : bvalid_q;

	assign commit_go = (state_q == S_COMMIT) && !(w_q.last && out_valid_q && !out_ready);
	assign q_ready   = (state_q == S_IDLE);

	assign out_valid      = out_valid_q;
	assign best_index     = best_index_q;
	assign best_a         = $signed(best_a_q);
	assign best_b         = $signed(best_b_q);
	assign best_c         = $signed(best_c_q);
	assign through_point  = through_q;
	assign all_degenerate = all_degen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			w_q          <= '0;
			take_q       <= 1'b0;
			bsq_q        <= '0;
			bden_q       <= '0;
			ba_q         <= '0;
			bb_q         <= '0;
			bc_q         <= '0;
			bpos_q       <= '0;
			pos_q        <= '0;
			bvalid_q     <= 1'b0;
			hit_q        <= 1'b0;
			p_q          <= '0;
			lo_q         <= '0;
			l_q          <= '0;
			r_q          <= '0;
			best_index_q <= '0;
			best_a_q     <= '0;
			best_b_q     <= '0;
			best_c_q     <= '0;
			through_q    <= 1'b0;
			all_degen_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !(commit_go && w_q.last))
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						w_q <= q_item;
						priority if (pos_q == '0 && !bvalid_q) begin
							take_q  <= 1'b1;
							state_q <= S_COMMIT;
						end else if (q_item.degen) begin
							take_q  <= 1'b0;
							state_q <= S_COMMIT;
						end else if (!bvalid_q) begin
							take_q  <= 1'b1;
							state_q <= S_COMMIT;
						end else begin
							state_q <= S_M0;
						end
					end
				end
				S_M0: begin
					p_q     <= mul_p;
					state_q <= S_M1;
				end
				S_M1: begin
					p_q     <= mul_p;
					lo_q    <= p_q;
					state_q <= S_M2;
				end
				S_M2: begin
					p_q     <= mul_p;
					l_q     <= {p_q, {MUL_W{1'b0}}} + WIDE_W'(lo_q);
					state_q <= S_M3;
				end
				S_M3: begin
					p_q     <= mul_p;
					lo_q    <= p_q;
					state_q <= S_M4;
				end
				S_M4: begin
					r_q     <= {p_q, {MUL_W{1'b0}}} + WIDE_W'(lo_q);
					state_q <= S_CMP;
				end
				S_CMP: begin
					take_q  <= (l_q < r_q);
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (commit_go) begin
						state_q <= S_IDLE;
						if (w_q.last) begin
							out_valid_q  <= 1'b1;
							best_index_q <= IDX_W'(nx_pos);
							best_a_q     <= nx_a;
							best_b_q     <= nx_b;
							best_c_q     <= nx_c;
							through_q    <= hit_q || w_q.hit;
							all_degen_q  <= !nx_valid;
							bsq_q        <= '0;
							bden_q       <= '0;
							ba_q         <= '0;
							bb_q         <= '0;
							bc_q         <= '0;
							bpos_q       <= '0;
							pos_q        <= '0;
							bvalid_q     <= 1'b0;
							hit_q        <= 1'b0;
						end else begin
							hit_q <= hit_q || w_q.hit;
							if (take_q) begin
								bsq_q    <= w_q.sq;
								bden_q   <= w_q.den;
								ba_q     <= w_q.a;
								bb_q     <= w_q.b;
								bc_q     <= w_q.c;
								bpos_q   <= pos_q;
								bvalid_q <= !w_q.degen;
							end
							if (pos_q < POS_W'(MAX_LINES - 1))
								pos_q <= pos_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[design/nearest_line_to_point.sv]
// Top level of the nearest-line-to-point block.
// Instantiates nlp_front, nlp_fifo and nlp_back; depends on nlp_pkg.
//
// Lines a*x+b*y+c=0 stream in as items; the query point is set through the
// write port (index 0 point_x, index 1 point_y) by the user only while idle,
// which the block does not enforce. The front pipeline takes one item per
// cycle unless the queue fills, forms |num|^2 and a^2+b^2 in four stages and
// feeds a four-entry queue. The compare engine takes one item at a time; one
// needing no compare (first line of a set, degenerate line, or no valid best
// yet) commits at once, any other runs the exact 96-bit cross-multiplied
// compare as four partial products on one shared 32x32 multiplier. A set's
// result appears on the output register after its last line is committed and
// holds there until taken while further lines keep flowing in.
`default_nettype none

module nearest_line_to_point (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [nlp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [nlp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic signed [nlp_pkg::COEF_W-1:0] coef_a,
	input  wire logic signed [nlp_pkg::COEF_W-1:0] coef_b,
	input  wire logic signed [nlp_pkg::COEF_W-1:0] coef_c,
	input  wire logic                              last,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [nlp_pkg::IDX_W-1:0]              best_index,
	output logic signed [nlp_pkg::COEF_W-1:0]      best_a,
	output logic signed [nlp_pkg::COEF_W-1:0]      best_b,
	output logic signed [nlp_pkg::COEF_W-1:0]      best_c,
	output logic                                   through_point,
	output logic                                   all_degenerate
);
	import nlp_pkg::*;

	logic  fq_valid, fq_ready;
	item_t fq_item;
	logic  qb_valid, qb_ready;
	item_t qb_item;

	nlp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.coef_a    (coef_a),
		.coef_b    (coef_b),
		.coef_c    (coef_c),
		.last      (last),
		.q_valid   (fq_valid),
		.q_ready   (fq_ready),
		.q_item    (fq_item)
	);

	nlp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_item  (fq_item),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_item  (qb_item)
	);

	nlp_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (qb_valid),
		.q_ready        (qb_ready),
		.q_item         (qb_item),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.best_index     (best_index),
		.best_a         (best_a),
		.best_b         (best_b),
		.best_c         (best_c),
		.through_point  (through_point),
		.all_degenerate (all_degenerate)
	);

endmodule

`default_nettype wire
